### src/json_string_escaper_assert.svh
// Assertion macros shared by the escaper's modules.
// All checks sample on the rising edge of i_clk.
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

// Check that is switched off while reset is held.
`define JSE_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("%m: check failed");

// Check that also holds across reset.
`define JSE_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge i_clk) prop) \
    else $error("%m: check failed");

`endif

### src/jse_pkg.sv
package jse_pkg;

    localparam logic [7:0] QUOTE_CHAR  = 8'h22;
    localparam logic [7:0] BSLASH_CHAR = 8'h5C;
    localparam logic [7:0] U_CHAR      = 8'h75;
    localparam logic [7:0] ZERO_CHAR   = 8'h30;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] CTRL_LIMIT  = 8'd32;
    localparam logic [3:0] NIBBLE_MASK = 4'd15;
    localparam logic [3:0] DIGIT_LIMIT = 4'd10;

    // Descriptor queue between classifier and emitter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Longest output run of one item: quote, six-byte escape, quote.
    localparam int RUN_MAX = 8;
    localparam int POS_W   = $clog2(RUN_MAX);
    localparam int LEN_W   = $clog2(RUN_MAX + 1);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PLAIN,
        KIND_SHORT,
        KIND_UNICODE
    } t_kind;

    // One classified input item. For KIND_SHORT, data holds the second
    // character of the escape; otherwise it holds the raw byte.
    typedef struct packed {
        logic       start_q;
        logic       end_q;
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [3:0] n;
        n = nib & NIBBLE_MASK;
        if (n < DIGIT_LIMIT) begin
            return ZERO_CHAR + {4'd0, n};
        end
        return LOWER_A + {4'd0, n - DIGIT_LIMIT};
    endfunction

endpackage

### src/jse_front.sv
// Classifies each incoming byte into an escape kind and queues the
// descriptor. Items that produce no output are accepted and dropped here.
module jse_front
    import jse_pkg::*;
(
    input  logic       i_s_tvalid,
    input  logic [7:0] i_s_tdata,
    input  logic [1:0] i_s_tuser,
    input  logic       i_s_tlast,
    input  logic       i_full,
    output logic       o_s_tready,
    output logic       o_push,
    output t_item      o_item
);

    logic [7:0] w_byte;
    logic       w_has;
    t_kind      w_kind;
    logic [7:0] w_data;

    assign w_byte = i_s_tdata;
    assign w_has  = i_s_tuser[0];

    always_comb begin
        w_kind = KIND_PLAIN;
        w_data = w_byte;
        case (w_byte)
            8'h5C: begin
                w_kind = KIND_SHORT;
                w_data = 8'h5C;
            end
            8'h22: begin
                w_kind = KIND_SHORT;
                w_data = 8'h22;
            end
            8'h0A: begin
                w_kind = KIND_SHORT;
                w_data = 8'h6E;
            end
            8'h09: begin
                w_kind = KIND_SHORT;
                w_data = 8'h74;
            end
            8'h0D: begin
                w_kind = KIND_SHORT;
                w_data = 8'h72;
            end
            8'h0C: begin
                w_kind = KIND_SHORT;
                w_data = 8'h66;
            end
            8'h08: begin
                w_kind = KIND_SHORT;
                w_data = 8'h62;
            end
            default: begin
                if (w_byte < CTRL_LIMIT) begin
                    w_kind = KIND_UNICODE;
                end
            end
        endcase
        if (!w_has) begin
            w_kind = KIND_NONE;
        end
    end

    assign o_s_tready     = !i_full;
    assign o_item.start_q = i_s_tuser[1];
    assign o_item.end_q   = i_s_tlast;
    assign o_item.kind    = w_kind;
    assign o_item.data    = w_data;

    // An item with no byte and no quote flag leaves nothing to emit.
    assign o_push = i_s_tvalid && !i_full &&
                    (w_has || i_s_tuser[1] || i_s_tlast);

endmodule

### src/jse_queue.sv
`include "json_string_escaper_assert.svh"

module jse_queue
    import jse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count;
    logic [QUEUE_AW-1:0]  n_wr_ptr;
    logic [QUEUE_AW-1:0]  n_rd_ptr;
    logic [QUEUE_CW-1:0]  n_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `JSE_ASSERT(a_no_overflow, i_push |-> !o_full)
    `JSE_ASSERT(a_no_underflow, i_pop |-> !o_empty)
    `JSE_ASSERT(a_ptr_count, (r_wr_ptr - r_rd_ptr) == r_count[QUEUE_AW-1:0])

endmodule

### src/jse_back.sv
`include "json_string_escaper_assert.svh"

// Walks the head descriptor one output byte per cycle into an output
// register when not stalled, and pops it with the byte that ends its run.
module jse_back
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_item      i_head,
    input  logic       i_m_tready,
    output logic       o_pop,
    output logic       o_m_tvalid,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_valid;
    logic             n_valid;
    logic [7:0]       r_byte;
    logic             r_last;

    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_total;
    logic [LEN_W-1:0] w_p;
    logic [LEN_W-1:0] w_q;
    logic [7:0]       w_byte;
    logic             w_last;
    logic             w_load;
    logic             w_emit;

    function automatic logic [7:0] esc_byte(input t_item it, input logic [LEN_W-1:0] q);
        logic [7:0] b;
        b = it.data;
        case (it.kind)
            KIND_SHORT: begin
                if (q == '0) begin
                    b = BSLASH_CHAR;
                end
            end
            KIND_UNICODE: begin
                case (q)
                    LEN_W'(0): b = BSLASH_CHAR;
                    LEN_W'(1): b = U_CHAR;
                    LEN_W'(2): b = ZERO_CHAR;
                    LEN_W'(3): b = ZERO_CHAR;
                    LEN_W'(4): b = hex_digit(it.data[7:4]);
                    default:   b = hex_digit(it.data[3:0]);
                endcase
            end
            default: b = it.data;
        endcase
        return b;
    endfunction

    always_comb begin
        case (i_head.kind)
            KIND_PLAIN:   w_len = LEN_W'(1);
            KIND_SHORT:   w_len = LEN_W'(2);
            KIND_UNICODE: w_len = LEN_W'(6);
            default:      w_len = '0;
        endcase
        w_total = w_len + LEN_W'(i_head.start_q) + LEN_W'(i_head.end_q);
        w_p     = LEN_W'(r_pos);
        w_q     = w_p - LEN_W'(i_head.start_q);
        if (i_head.start_q && (w_p == '0)) begin
            w_byte = QUOTE_CHAR;
        end else if (w_q < w_len) begin
            w_byte = esc_byte(i_head, w_q);
        end else begin
            w_byte = QUOTE_CHAR;
        end
        w_last = (w_p == w_total - 1'b1);
    end

    assign w_load = !r_valid || i_m_tready;
    assign w_emit = w_load && !i_empty;
    assign o_pop  = w_emit && w_last;

    always_comb begin
        n_pos = r_pos;
        if (o_pop) begin
            n_pos = '0;
        end else if (w_emit) begin
            n_pos = r_pos + 1'b1;
        end
        n_valid = r_valid;
        if (w_load) begin
            n_valid = w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte <= w_byte;
            r_last <= w_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;

    `JSE_ASSERT(a_pos_in_run, !i_empty |-> (w_p < w_total))
    `JSE_ASSERT(a_pos_idle, i_empty |-> (r_pos == '0))
    `JSE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!r_valid && (r_pos == '0)))

endmodule

### src/json_string_escaper.sv
// JSON string escaper: takes one string byte per request and sends out its
// JSON text, with an opening quote when s_tuser[1] is set and a closing
// quote when s_tlast is set. Quote, backslash, newline, tab, carriage
// return, form feed and backspace become two-byte escapes, other control
// bytes become a six-byte \u00xx escape, everything else passes through.
// Each output request carries one byte, and m_tlast marks the final byte
// caused by an input request. An input request produces one to eight
// bytes; the output register sends one byte per cycle while m_tready
// allows, so plain bytes stream at one per cycle when not stalled. A
// four-entry descriptor queue between classifier and emitter absorbs
// short stalls on either side. Requests with no byte and no quote flag
// produce nothing and are taken without delay while the queue has room.
module json_string_escaper
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [1:0] s_tuser,   // [0] has_byte, [1] string_start
    input  logic       s_tlast,   // string_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last_of_run
);

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_item w_item;
    t_item w_head;

    jse_front u_front (
        .i_s_tvalid (s_tvalid),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .i_full     (w_full),
        .o_s_tready (s_tready),
        .o_push     (w_push),
        .o_item     (w_item)
    );

    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    jse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .i_m_tready (m_tready),
        .o_pop      (w_pop),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

endmodule
